// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/kcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and constants of the keypad code lock with alarm.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int unsigned CODE_BYTES   = 6;
    localparam int unsigned PASS_W       = 8 * CODE_BYTES;
    localparam int unsigned CFG_INDEX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PASSCODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_TICKS = 2'd2;

    // Register values after reset: '#1234#', 5 and 10
    localparam logic [PASS_W-1:0] PASSCODE_RST    = 48'h2334_3332_3123;
    localparam logic [7:0]        LOCK_TICKS_RST  = 8'd5;
    localparam logic [7:0]        ALARM_TICKS_RST = 8'd10;

    // Lock mode codes as seen on the result channel
    localparam logic [2:0] MODE_START      = 3'd0;
    localparam logic [2:0] MODE_LOCKED     = 3'd1;
    localparam logic [2:0] MODE_LOCKED_REL = 3'd2;
    localparam logic [2:0] MODE_UNLOCKED   = 3'd3;
    localparam logic [2:0] MODE_UNLOCK_REL = 3'd4;
    localparam logic [2:0] MODE_LOCKING    = 3'd5;

    // Display event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_CLEAR    = 3'd1;
    localparam logic [2:0] EV_ECHO     = 3'd2;
    localparam logic [2:0] EV_UNLOCKED = 3'd3;
    localparam logic [2:0] EV_LOCKING  = 3'd4;

    localparam logic [1:0] DOOR_ACTIVE = 2'd3;
    localparam logic [1:0] DOOR_IDLE   = 2'd0;
    localparam logic [7:0] COUNT_TOP   = 8'hFF;

    typedef struct packed {
        logic [PASS_W-1:0] passcode;
        logic [7:0]        locking_ticks;
        logic [7:0]        alarm_phase_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] lock_mode;
        logic [7:0] entered_count;
        logic       servo_closed;
        logic [1:0] door_signal;
        logic       beep;
        logic [2:0] display_event;
        logic [7:0] echo_char;
        logic [2:0] echo_column;
    } lock_res_t;

    typedef struct packed {
        logic tone;
        logic led;
    } alarm_res_t;

    // Expected character at a code position; positions past the code read zero
    function automatic logic [7:0] code_byte(input logic [PASS_W-1:0] code,
                                             input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = code[7:0];
            3'd1:    b = code[15:8];
            3'd2:    b = code[23:16];
            3'd3:    b = code[31:24];
            3'd4:    b = code[39:32];
            3'd5:    b = code[47:40];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== design/kcl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_cfg_regs
// Configuration register file: passcode, locking and alarm phase limits.
// ----------------------------------------------------------------------------
module kcl_cfg_regs
    import kcl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PASS_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PASSCODE:    cfg_next.passcode          = cfg_data;
                CFG_LOCK_TICKS:  cfg_next.locking_ticks     = cfg_data[7:0];
                CFG_ALARM_TICKS: cfg_next.alarm_phase_ticks = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.passcode          <= PASSCODE_RST;
            cfg_reg.locking_ticks     <= LOCK_TICKS_RST;
            cfg_reg.alarm_phase_ticks <= ALARM_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/kcl_lock_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_fsm
// Code-lock machine: key matching, release waits, locking countdown, servo.
// ----------------------------------------------------------------------------
module kcl_lock_fsm
    import kcl_pkg::*;
#(
    parameter int unsigned CODE_LENGTH = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] key_char,
    input  cfg_t       cfg,
    output lock_res_t  res
);

    localparam logic [7:0] CODE_LEN = 8'(CODE_LENGTH);

    typedef enum logic [2:0] {
        PH_START      = MODE_START,
        PH_LOCKED     = MODE_LOCKED,
        PH_LOCKREL    = MODE_LOCKED_REL,
        PH_UNLOCKED   = MODE_UNLOCKED,
        PH_UNLOCKREL  = MODE_UNLOCK_REL,
        PH_LOCKING    = MODE_LOCKING
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic       servo_reg, servo_next;
    logic [1:0] door_reg,  door_next;
    logic [2:0] ev;
    logic [7:0] ech;
    logic [2:0] col;
    logic       key_held;
    logic       code_hit;
    logic       code_done;

    assign key_held  = (key_char != 8'd0);
    assign code_hit  = (count_reg < CODE_LEN) &&
                       (code_byte(cfg.passcode, count_reg[2:0]) == key_char);
    assign code_done = (count_reg >= CODE_LEN);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        servo_next = servo_reg;
        door_next  = door_reg;
        ev         = EV_NONE;
        ech        = 8'd0;
        col        = 3'd0;
        case (phase_reg)
            PH_LOCKED, PH_UNLOCKED:
            begin
                if (key_held)
                begin
                    if (code_hit)
                    begin
                        ev         = EV_ECHO;
                        ech        = key_char;
                        col        = count_reg[2:0];
                        count_next = count_reg + 8'd1;
                    end
                    else
                    begin
                        ev         = EV_CLEAR;
                        count_next = 8'd0;
                    end
                    phase_next = (phase_reg == PH_LOCKED) ? PH_LOCKREL : PH_UNLOCKREL;
                end
            end
            PH_LOCKREL:
            begin
                if (!key_held)
                begin
                    if (!code_done)
                    begin
                        phase_next = PH_LOCKED;
                    end
                    else
                    begin
                        ev         = EV_UNLOCKED;
                        servo_next = 1'b0;
                        phase_next = PH_UNLOCKED;
                        count_next = 8'd0;
                    end
                end
            end
            PH_UNLOCKREL:
            begin
                if (!key_held)
                begin
                    if (!code_done)
                    begin
                        phase_next = PH_UNLOCKED;
                    end
                    else
                    begin
                        servo_next = 1'b0;
                        phase_next = PH_LOCKING;
                        count_next = 8'd0;
                        door_next  = DOOR_ACTIVE;
                    end
                end
            end
            PH_LOCKING:
            begin
                // a count at the top of its range ends the countdown
                if (count_reg <= cfg.locking_ticks && count_reg != COUNT_TOP)
                begin
                    ev         = EV_LOCKING;
                    count_next = count_reg + 8'd1;
                    door_next  = DOOR_ACTIVE;
                end
                else
                begin
                    ev         = EV_CLEAR;
                    phase_next = PH_LOCKED;
                    count_next = 8'd0;
                    servo_next = 1'b1;
                    door_next  = DOOR_IDLE;
                end
            end
            default:
            begin
                count_next = 8'd0;
                phase_next = PH_UNLOCKED;
                servo_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.lock_mode     = phase_next;
        res.entered_count = count_next;
        res.servo_closed  = servo_next;
        res.door_signal   = door_next;
        res.beep          = (phase_next == PH_LOCKING);
        res.display_event = ev;
        res.echo_char     = ech;
        res.echo_column   = col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            count_reg <= 8'd0;
            servo_reg <= 1'b0;
            door_reg  <= DOOR_IDLE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            servo_reg <= servo_next;
            door_reg  <= door_next;
        end
    end

endmodule

// ===== design/kcl_alarm_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_alarm_fsm
// Intrusion alarm: alternates tone-and-light and tone-only phases.
// ----------------------------------------------------------------------------
module kcl_alarm_fsm
    import kcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [2:0] lock_mode,
    input  logic       motion,
    input  logic [7:0] phase_ticks,
    output alarm_res_t res
);

    typedef enum logic [1:0] {
        AL_OFF        = 2'd0,
        AL_TONE_LIGHT = 2'd1,
        AL_TONE       = 2'd2
    } alarm_t;

    alarm_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic       on_lock;

    assign on_lock = (lock_mode == MODE_LOCKED) || (lock_mode == MODE_LOCKED_REL);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        case (phase_reg)
            AL_TONE_LIGHT, AL_TONE:
            begin
                // the counter is left as it is when the alarm stops
                if (lock_mode == MODE_UNLOCKED)
                begin
                    phase_next = AL_OFF;
                end
                else if (count_reg <= phase_ticks)
                begin
                    count_next = count_reg + 8'd1;
                end
                else
                begin
                    phase_next = (phase_reg == AL_TONE_LIGHT) ? AL_TONE : AL_TONE_LIGHT;
                    count_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = (on_lock && motion) ? AL_TONE_LIGHT : AL_OFF;
            end
        endcase
    end

    assign res.tone = (phase_next == AL_TONE_LIGHT) || (phase_next == AL_TONE);
    assign res.led  = (phase_next == AL_TONE_LIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= AL_OFF;
            count_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/keypad_code_lock_with_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_with_alarm
// Keypad code lock with intrusion alarm, one result per keypad tick.
// ----------------------------------------------------------------------------
// Each accepted tick gives exactly one result: the tick is captured in an input
// register, the lock and alarm machines work out their next state from it, and
// the result lands in an output register. A new tick is taken every cycle while
// the output is not stalled; the next-state logic of the two machines is
// combinational. cfg_ready is always high; write the registers only while no
// transaction is in flight.
module keypad_code_lock_with_alarm
    import kcl_pkg::*;
#(
    parameter int unsigned CODE_LENGTH = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PASS_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             key_char,
    input  logic                   motion,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             lock_mode,
    output logic [7:0]             entered_count,
    output logic                   servo_closed,
    output logic [1:0]             door_signal,
    output logic                   beep,
    output logic                   alarm_tone,
    output logic                   alarm_led,
    output logic [2:0]             display_event,
    output logic [7:0]             echo_char,
    output logic [2:0]             echo_column
);

    cfg_t       cfg;
    lock_res_t  lock_res;
    alarm_res_t alarm_res;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] key_reg;
    logic       motion_reg;
    logic       out_valid_reg, out_valid_next;
    lock_res_t  lock_out_reg;
    alarm_res_t alarm_out_reg;
    logic       accept;
    logic       advance;

    assign cfg_ready = 1'b1;

    kcl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kcl_lock_fsm #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_lock (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .key_char (key_reg),
        .cfg      (cfg),
        .res      (lock_res)
    );

    kcl_alarm_fsm u_alarm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .lock_mode   (lock_res.lock_mode),
        .motion      (motion_reg),
        .phase_ticks (cfg.alarm_phase_ticks),
        .res         (alarm_res)
    );

    // Move the held tick on whenever the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= key_char;
            motion_reg <= motion;
        end
        if (advance)
        begin
            lock_out_reg  <= lock_res;
            alarm_out_reg <= alarm_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lock_mode     = lock_out_reg.lock_mode;
    assign entered_count = lock_out_reg.entered_count;
    assign servo_closed  = lock_out_reg.servo_closed;
    assign door_signal   = lock_out_reg.door_signal;
    assign beep          = lock_out_reg.beep;
    assign display_event = lock_out_reg.display_event;
    assign echo_char     = lock_out_reg.echo_char;
    assign echo_column   = lock_out_reg.echo_column;
    assign alarm_tone    = alarm_out_reg.tone;
    assign alarm_led     = alarm_out_reg.led;

endmodule

// ===== design/kcl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the result channel of the keypad code lock.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcl_checker
    import kcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] lock_mode,
    input  logic       servo_closed,
    input  logic [1:0] door_signal,
    input  logic       beep,
    input  logic       alarm_tone,
    input  logic       alarm_led,
    input  logic [2:0] display_event
);

    // A beep only comes while locking, with the door driven and the servo open
    `ASSERT_IMP(beep_door, clk, rst_n, out_valid && beep,
        door_signal == DOOR_ACTIVE && !servo_closed && lock_mode == MODE_LOCKING)

    // Lights never run without the tone
    `ASSERT_IMP(led_tone, clk, rst_n, out_valid && alarm_led, alarm_tone)

    // An echoed character always leaves the machine waiting for key release
    `ASSERT_IMP(echo_release, clk, rst_n, out_valid && display_event == EV_ECHO,
        lock_mode == MODE_LOCKED_REL || lock_mode == MODE_UNLOCK_REL)

    // Hold a stalled transaction
    `ASSERT_NXT(out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(lock_mode) && $stable(display_event) && $stable(alarm_tone))

endmodule

bind keypad_code_lock_with_alarm kcl_checker u_kcl_checker (.*);
